FILE: hw/rtl/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg: shared definitions for the touch coordinate mapper
// Register indexes, reset values, field widths and the per-item flag bundle.
// ----------------------------------------------------------------------------
package tcm_pkg;

	// Default width of the converter readings and calibration bounds.
	localparam int RAW_BITS_DEFAULT = 12;

	// Fixed field widths.
	localparam int SIZE_W     = 12;
	localparam int FLIP_W     = 2;
	localparam int PRES_W     = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int SCALE_W    = 10;

	// Pressure is scaled by this factor before the division by Z2.
	localparam logic [SCALE_W-1:0] PRESSURE_SCALE = 10'd1000;

	// Number of register stages in each pipelined divider.
	localparam int DIV_STAGES = 4;

	// Bit positions in the flip mode register.
	localparam int FLIP_X_BIT = 0;
	localparam int FLIP_Y_BIT = 1;

	// Reset values of the configuration registers.
	localparam int                 CAL_LOW_RESET  = 0;
	localparam int                 CAL_HIGH_RESET = 4095;
	localparam logic [SIZE_W-1:0]  WIDTH_RESET    = 12'd320;
	localparam logic [SIZE_W-1:0]  HEIGHT_RESET   = 12'd240;
	localparam logic [FLIP_W-1:0]  FLIP_RESET     = 2'd0;
	localparam logic [PRES_W-1:0]  CEILING_RESET  = 16'hFFFF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_X_LOW        = 4'd0,
		REG_CAL_X_HIGH       = 4'd1,
		REG_CAL_Y_LOW        = 4'd2,
		REG_CAL_Y_HIGH       = 4'd3,
		REG_SCREEN_WIDTH     = 4'd4,
		REG_SCREEN_HEIGHT    = 4'd5,
		REG_FLIP_MODE        = 4'd6,
		REG_PRESSURE_CEILING = 4'd7
	} cfg_reg_t;

	// Special-case flags that travel beside the dividers with each item.
	typedef struct packed {
		logic x_zero;   // X reading at or below its low bound, or window inverted
		logic x_full;   // X reading at or above its high bound
		logic y_zero;
		logic y_full;
		logic z1_zero;
		logic z2_zero;
	} flags_t;

endpackage

FILE: hw/rtl/touch_coordinate_mapper.sv
// ----------------------------------------------------------------------------
// touch_coordinate_mapper: resistive touch sample to screen coordinates
// Maps X and Y readings through calibration windows onto the screen size and
// estimates contact pressure as Z1*1000/Z2 clamped to a ceiling.
// ----------------------------------------------------------------------------
// The mapper takes one touch sample per clock unless the pipeline is stalled
// and returns one result item for every sample, in order. The pipeline holds
// seven register stages: a window check stage, a multiply stage, four stages
// of the pipelined restoring dividers (one each for X, Y and pressure, several
// quotient bits per stage) and the output register, where limits, flips and
// the pressure clamp are applied. Back pressure is global: while a result is
// held by result_stall the whole pipeline freezes, so sample_stall follows
// result_valid and result_stall. Configuration registers are written through
// the cfg port, which is always ready; they should only be changed while no
// item is in flight.

module touch_coordinate_mapper #(
	parameter int RAW_BITS = tcm_pkg::RAW_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Sample channel.
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic [RAW_BITS-1:0]             raw_x,
	input  logic [RAW_BITS-1:0]             raw_y,
	input  logic [RAW_BITS-1:0]             touch_z1,
	input  logic [RAW_BITS-1:0]             touch_z2,

	// Result channel.
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            map_status,
	output logic [tcm_pkg::SIZE_W-1:0]      display_x,
	output logic [tcm_pkg::SIZE_W-1:0]      display_y,
	output logic [tcm_pkg::PRES_W-1:0]      pressure,

	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int NX_W     = RAW_BITS + tcm_pkg::SIZE_W;
	localparam int NP_W     = RAW_BITS + tcm_pkg::SCALE_W;
	localparam int DIV_LAST = tcm_pkg::DIV_STAGES - 1;

	logic [RAW_BITS-1:0]          cal_x_low, cal_x_high, cal_y_low, cal_y_high;
	logic [tcm_pkg::SIZE_W-1:0]   screen_width, screen_height;
	logic [tcm_pkg::FLIP_W-1:0]   flip_mode;
	logic [tcm_pkg::PRES_W-1:0]   pressure_ceiling;

	logic                         en;
	logic                         front_vld;
	tcm_pkg::flags_t              front_flg;
	logic [NX_W-1:0]              num_x, num_y;
	logic [NP_W-1:0]              num_p;
	logic [RAW_BITS-1:0]          den_x, den_y, den_p;
	logic [tcm_pkg::SIZE_W-1:0]   quo_x, quo_y;
	logic [NP_W-1:0]              quo_p;

	// Valid bits and flags that ride alongside the divider stages.
	logic                         vld_div_s [tcm_pkg::DIV_STAGES];
	tcm_pkg::flags_t              flg_div_s [tcm_pkg::DIV_STAGES];

	// The pipeline advances unless a finished result is being held.
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	tcm_cfg #(.RAW_BITS(RAW_BITS)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (cfg_valid),
		.ready      (cfg_ready),
		.index      (cfg_index),
		.data       (cfg_data),
		.cal_x_low  (cal_x_low),
		.cal_x_high (cal_x_high),
		.cal_y_low  (cal_y_low),
		.cal_y_high (cal_y_high),
		.width      (screen_width),
		.height     (screen_height),
		.flip       (flip_mode),
		.ceiling    (pressure_ceiling)
	);

	tcm_front #(.RAW_BITS(RAW_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (sample_valid),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.z1         (touch_z1),
		.z2         (touch_z2),
		.cal_x_low  (cal_x_low),
		.cal_x_high (cal_x_high),
		.cal_y_low  (cal_y_low),
		.cal_y_high (cal_y_high),
		.width      (screen_width),
		.height     (screen_height),
		.vld        (front_vld),
		.flg        (front_flg),
		.num_x      (num_x),
		.num_y      (num_y),
		.num_p      (num_p),
		.den_x      (den_x),
		.den_y      (den_y),
		.den_p      (den_p)
	);

	// An in-window offset times the size divided by the span is always below
	// the size, so twelve quotient bits cover both axes.
	tcm_div #(
		.NUM_W (NX_W),
		.DEN_W (RAW_BITS),
		.Q_W   (tcm_pkg::SIZE_W),
		.NSTG  (tcm_pkg::DIV_STAGES)
	) u_div_x (
		.clk (clk),
		.en  (en),
		.num (num_x),
		.den (den_x),
		.quo (quo_x)
	);

	tcm_div #(
		.NUM_W (NX_W),
		.DEN_W (RAW_BITS),
		.Q_W   (tcm_pkg::SIZE_W),
		.NSTG  (tcm_pkg::DIV_STAGES)
	) u_div_y (
		.clk (clk),
		.en  (en),
		.num (num_y),
		.den (den_y),
		.quo (quo_y)
	);

	// The pressure quotient is kept at full width and clamped afterwards.
	tcm_div #(
		.NUM_W (NP_W),
		.DEN_W (RAW_BITS),
		.Q_W   (NP_W),
		.NSTG  (tcm_pkg::DIV_STAGES)
	) u_div_p (
		.clk (clk),
		.en  (en),
		.num (num_p),
		.den (den_p),
		.quo (quo_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tcm_pkg::DIV_STAGES; k++) begin
				vld_div_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_div_s[0] <= front_vld;
			for (int k = 1; k < tcm_pkg::DIV_STAGES; k++) begin
				vld_div_s[k] <= vld_div_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_div_s[0] <= front_flg;
			for (int k = 1; k < tcm_pkg::DIV_STAGES; k++) begin
				flg_div_s[k] <= flg_div_s[k-1];
			end
		end
	end

	tcm_back #(.RAW_BITS(RAW_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_div_s[DIV_LAST]),
		.flg     (flg_div_s[DIV_LAST]),
		.quo_x   (quo_x),
		.quo_y   (quo_y),
		.quo_p   (quo_p),
		.width   (screen_width),
		.height  (screen_height),
		.flip    (flip_mode),
		.ceiling (pressure_ceiling),
		.valid   (result_valid),
		.status  (map_status),
		.pos_x   (display_x),
		.pos_y   (display_y),
		.pres    (pressure)
	);

	// A frozen pipeline must neither drop nor duplicate items in flight.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (front_vld == $past(front_vld)) &&
			(vld_div_s[DIV_LAST] == $past(vld_div_s[DIV_LAST])))
		else $error("pipeline valid bits moved while stalled");

	// A new result can only come out of the last divider stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(vld_div_s[DIV_LAST]))
		else $error("result appeared without an item in the last divider stage");

	// An invalid screen size forces all result fields to zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && map_status |->
			(display_x == '0) && (display_y == '0) && (pressure == '0))
		else $error("invalid status with nonzero result fields");

endmodule

FILE: hw/rtl/tcm_cfg.sv
// ----------------------------------------------------------------------------
// tcm_cfg: configuration register file
// Holds the calibration window, screen size, flip mode and pressure ceiling.
// ----------------------------------------------------------------------------
module tcm_cfg #(
	parameter int RAW_BITS = tcm_pkg::RAW_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid,
	output logic                            ready,
	input  logic [tcm_pkg::CFG_IDX_W-1:0]   index,
	input  logic [tcm_pkg::CFG_DATA_W-1:0]  data,
	output logic [RAW_BITS-1:0]             cal_x_low,
	output logic [RAW_BITS-1:0]             cal_x_high,
	output logic [RAW_BITS-1:0]             cal_y_low,
	output logic [RAW_BITS-1:0]             cal_y_high,
	output logic [tcm_pkg::SIZE_W-1:0]      width,
	output logic [tcm_pkg::SIZE_W-1:0]      height,
	output logic [tcm_pkg::FLIP_W-1:0]      flip,
	output logic [tcm_pkg::PRES_W-1:0]      ceiling
);

	logic [RAW_BITS-1:0]          cal_x_low_q;
	logic [RAW_BITS-1:0]          cal_x_high_q;
	logic [RAW_BITS-1:0]          cal_y_low_q;
	logic [RAW_BITS-1:0]          cal_y_high_q;
	logic [tcm_pkg::SIZE_W-1:0]   width_q;
	logic [tcm_pkg::SIZE_W-1:0]   height_q;
	logic [tcm_pkg::FLIP_W-1:0]   flip_q;
	logic [tcm_pkg::PRES_W-1:0]   ceiling_q;

	// Writes are always taken.
	assign ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_x_low_q  <= RAW_BITS'(tcm_pkg::CAL_LOW_RESET);
			cal_x_high_q <= RAW_BITS'(tcm_pkg::CAL_HIGH_RESET);
			cal_y_low_q  <= RAW_BITS'(tcm_pkg::CAL_LOW_RESET);
			cal_y_high_q <= RAW_BITS'(tcm_pkg::CAL_HIGH_RESET);
			width_q      <= tcm_pkg::WIDTH_RESET;
			height_q     <= tcm_pkg::HEIGHT_RESET;
			flip_q       <= tcm_pkg::FLIP_RESET;
			ceiling_q    <= tcm_pkg::CEILING_RESET;
		end else if (valid) begin
			unique case (tcm_pkg::cfg_reg_t'(index))
				tcm_pkg::REG_CAL_X_LOW:        cal_x_low_q  <= data[RAW_BITS-1:0];
				tcm_pkg::REG_CAL_X_HIGH:       cal_x_high_q <= data[RAW_BITS-1:0];
				tcm_pkg::REG_CAL_Y_LOW:        cal_y_low_q  <= data[RAW_BITS-1:0];
				tcm_pkg::REG_CAL_Y_HIGH:       cal_y_high_q <= data[RAW_BITS-1:0];
				tcm_pkg::REG_SCREEN_WIDTH:     width_q      <= data[tcm_pkg::SIZE_W-1:0];
				tcm_pkg::REG_SCREEN_HEIGHT:    height_q     <= data[tcm_pkg::SIZE_W-1:0];
				tcm_pkg::REG_FLIP_MODE:        flip_q       <= data[tcm_pkg::FLIP_W-1:0];
				tcm_pkg::REG_PRESSURE_CEILING: ceiling_q    <= data[tcm_pkg::PRES_W-1:0];
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

	assign cal_x_low  = cal_x_low_q;
	assign cal_x_high = cal_x_high_q;
	assign cal_y_low  = cal_y_low_q;
	assign cal_y_high = cal_y_high_q;
	assign width      = width_q;
	assign height     = height_q;
	assign flip       = flip_q;
	assign ceiling    = ceiling_q;

endmodule

FILE: hw/rtl/tcm_front.sv
// ----------------------------------------------------------------------------
// tcm_front: first two pipeline stages
// Stage 1 compares readings with the window and forms the offsets and spans;
// stage 2 forms the dividends with one multiplier per lane.
// ----------------------------------------------------------------------------
module tcm_front #(
	parameter int RAW_BITS = tcm_pkg::RAW_BITS_DEFAULT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_vld,
	input  logic [RAW_BITS-1:0]                        raw_x,
	input  logic [RAW_BITS-1:0]                        raw_y,
	input  logic [RAW_BITS-1:0]                        z1,
	input  logic [RAW_BITS-1:0]                        z2,
	input  logic [RAW_BITS-1:0]                        cal_x_low,
	input  logic [RAW_BITS-1:0]                        cal_x_high,
	input  logic [RAW_BITS-1:0]                        cal_y_low,
	input  logic [RAW_BITS-1:0]                        cal_y_high,
	input  logic [tcm_pkg::SIZE_W-1:0]                 width,
	input  logic [tcm_pkg::SIZE_W-1:0]                 height,
	output logic                                       vld,
	output tcm_pkg::flags_t                            flg,
	output logic [RAW_BITS+tcm_pkg::SIZE_W-1:0]        num_x,
	output logic [RAW_BITS+tcm_pkg::SIZE_W-1:0]        num_y,
	output logic [RAW_BITS+tcm_pkg::SCALE_W-1:0]       num_p,
	output logic [RAW_BITS-1:0]                        den_x,
	output logic [RAW_BITS-1:0]                        den_y,
	output logic [RAW_BITS-1:0]                        den_p
);

	localparam int NX_W = RAW_BITS + tcm_pkg::SIZE_W;
	localparam int NP_W = RAW_BITS + tcm_pkg::SCALE_W;

	tcm_pkg::flags_t      flg_d;
	logic                 vld_s1;
	tcm_pkg::flags_t      flg_s1;
	logic [RAW_BITS-1:0]  dx_s1, dy_s1, denx_s1, deny_s1, z1_s1, z2_s1;
	logic                 vld_s2;
	tcm_pkg::flags_t      flg_s2;
	logic [NX_W-1:0]      numx_s2, numy_s2;
	logic [NP_W-1:0]      nump_s2;
	logic [RAW_BITS-1:0]  denx_s2, deny_s2, z2_s2;

	always_comb begin
		flg_d.x_zero  = (cal_x_low >= cal_x_high) || (raw_x <= cal_x_low);
		flg_d.x_full  = (raw_x >= cal_x_high);
		flg_d.y_zero  = (cal_y_low >= cal_y_high) || (raw_y <= cal_y_low);
		flg_d.y_full  = (raw_y >= cal_y_high);
		flg_d.z1_zero = (z1 == '0);
		flg_d.z2_zero = (z2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s1  <= flg_d;
			dx_s1   <= raw_x - cal_x_low;
			dy_s1   <= raw_y - cal_y_low;
			denx_s1 <= cal_x_high - cal_x_low;
			deny_s1 <= cal_y_high - cal_y_low;
			z1_s1   <= z1;
			z2_s1   <= z2;

			flg_s2  <= flg_s1;
			numx_s2 <= NX_W'(dx_s1) * NX_W'(width);
			numy_s2 <= NX_W'(dy_s1) * NX_W'(height);
			nump_s2 <= NP_W'(z1_s1) * NP_W'(tcm_pkg::PRESSURE_SCALE);
			denx_s2 <= denx_s1;
			deny_s2 <= deny_s1;
			z2_s2   <= z2_s1;
		end
	end

	assign vld   = vld_s2;
	assign flg   = flg_s2;
	assign num_x = numx_s2;
	assign num_y = numy_s2;
	assign num_p = nump_s2;
	assign den_x = denx_s2;
	assign den_y = deny_s2;
	assign den_p = z2_s2;

endmodule

FILE: hw/rtl/tcm_div.sv
// ----------------------------------------------------------------------------
// tcm_div: pipelined restoring divider
// Produces Q_W quotient bits over NSTG register stages, a few bits per stage.
// ----------------------------------------------------------------------------
module tcm_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 12,
	parameter int Q_W   = 12,
	parameter int NSTG  = tcm_pkg::DIV_STAGES
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [Q_W-1:0]    quo
);

	// The partial remainder sits in the upper DEN_W bits; the lower Q_W bits
	// shift the dividend out and the quotient in. The upper quotient bits are
	// assumed zero, that is num >> Q_W is below den.
	localparam int ACC_W = DEN_W + Q_W;
	localparam int SPS   = (Q_W + NSTG - 1) / NSTG;

	logic [ACC_W-1:0] acc_s [NSTG];
	logic [DEN_W-1:0] den_s [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [ACC_W-1:0] acc_in;
		logic [DEN_W-1:0] den_in;
		logic [ACC_W-1:0] acc_nx;

		if (k == 0) begin : g_first
			assign acc_in = ACC_W'(num);
			assign den_in = den;
		end else begin : g_next
			assign acc_in = acc_s[k-1];
			assign den_in = den_s[k-1];
		end

		always_comb begin
			logic [DEN_W:0]   rem;
			logic [DEN_W:0]   dif;
			logic [ACC_W-1:0] a;
			a   = acc_in;
			rem = '0;
			dif = '0;
			for (int j = 0; j < SPS; j++) begin
				if (k * SPS + j < Q_W) begin
					rem = a[ACC_W-1:Q_W-1];
					dif = rem - {1'b0, den_in};
					if (rem >= {1'b0, den_in}) begin
						a = {dif[DEN_W-1:0], a[Q_W-2:0], 1'b1};
					end else begin
						a = {rem[DEN_W-1:0], a[Q_W-2:0], 1'b0};
					end
				end
			end
			acc_nx = a;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k] <= acc_nx;
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = acc_s[NSTG-1][Q_W-1:0];

endmodule

FILE: hw/rtl/tcm_back.sv
// ----------------------------------------------------------------------------
// tcm_back: result stage
// Applies the window limits, flips and pressure clamp, then registers the item.
// ----------------------------------------------------------------------------
module tcm_back #(
	parameter int RAW_BITS = tcm_pkg::RAW_BITS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  tcm_pkg::flags_t                       flg,
	input  logic [tcm_pkg::SIZE_W-1:0]            quo_x,
	input  logic [tcm_pkg::SIZE_W-1:0]            quo_y,
	input  logic [RAW_BITS+tcm_pkg::SCALE_W-1:0]  quo_p,
	input  logic [tcm_pkg::SIZE_W-1:0]            width,
	input  logic [tcm_pkg::SIZE_W-1:0]            height,
	input  logic [tcm_pkg::FLIP_W-1:0]            flip,
	input  logic [tcm_pkg::PRES_W-1:0]            ceiling,
	output logic                                  valid,
	output logic                                  status,
	output logic [tcm_pkg::SIZE_W-1:0]            pos_x,
	output logic [tcm_pkg::SIZE_W-1:0]            pos_y,
	output logic [tcm_pkg::PRES_W-1:0]            pres
);

	localparam int QP_W = RAW_BITS + tcm_pkg::SCALE_W;

	logic                         bad_size;
	logic [tcm_pkg::SIZE_W-1:0]   wmax, hmax, px, py, fx, fy;
	logic [tcm_pkg::PRES_W-1:0]   pr;
	logic                         valid_q;
	logic                         status_q;
	logic [tcm_pkg::SIZE_W-1:0]   pos_x_q, pos_y_q;
	logic [tcm_pkg::PRES_W-1:0]   pres_q;

	always_comb begin
		bad_size = (width == '0) || (height == '0);
		wmax     = width - tcm_pkg::SIZE_W'(1);
		hmax     = height - tcm_pkg::SIZE_W'(1);

		px = flg.x_zero ? '0 : (flg.x_full ? wmax : quo_x);
		py = flg.y_zero ? '0 : (flg.y_full ? hmax : quo_y);
		fx = flip[tcm_pkg::FLIP_X_BIT] ? (wmax - px) : px;
		fy = flip[tcm_pkg::FLIP_Y_BIT] ? (hmax - py) : py;

		if (flg.z1_zero) begin
			pr = '0;
		end else if (flg.z2_zero || (quo_p > QP_W'(ceiling))) begin
			pr = ceiling;
		end else begin
			pr = quo_p[tcm_pkg::PRES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= bad_size;
			pos_x_q  <= bad_size ? '0 : fx;
			pos_y_q  <= bad_size ? '0 : fy;
			pres_q   <= bad_size ? '0 : pr;
		end
	end

	assign valid  = valid_q;
	assign status = status_q;
	assign pos_x  = pos_x_q;
	assign pos_y  = pos_y_q;
	assign pres   = pres_q;

endmodule
